### rtl/evcp_pkg.sv
// Shared types, codes and field widths of the control-pilot state detector.
`default_nettype none

package evcp_pkg;

    // Fixed field widths of the stream and configuration channels
    localparam int SAMPLE_FIELD_W = 12;
    localparam int VOLT_W         = 16;
    localparam int CODE_W         = 4;
    localparam int STATUS_W       = 2;
    localparam int DUTY_W         = 7;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 40;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DUTY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THR12  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THR9   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THR6   = 3'd6;

    // Per-sample status codes
    localparam logic [STATUS_W-1:0] STS_ACCUM   = 2'd0;
    localparam logic [STATUS_W-1:0] STS_AVG_DONE = 2'd1;
    localparam logic [STATUS_W-1:0] STS_IGNORED = 2'd2;

    // Pilot state codes
    localparam logic [CODE_W-1:0] PS_DEFAULT = 4'd0;
    localparam logic [CODE_W-1:0] PS_DC12    = 4'd1;
    localparam logic [CODE_W-1:0] PS_DC9     = 4'd2;
    localparam logic [CODE_W-1:0] PS_DC6     = 4'd3;
    localparam logic [CODE_W-1:0] PS_PWM12   = 4'd4;
    localparam logic [CODE_W-1:0] PS_PWM9    = 4'd5;
    localparam logic [CODE_W-1:0] PS_PWM6    = 4'd6;
    localparam logic [CODE_W-1:0] PS_ERR_PWM = 4'd7;
    localparam logic [CODE_W-1:0] PS_ERR_DC  = 4'd8;

    // Duty value that means a steady DC pilot
    localparam logic [DUTY_W-1:0] DUTY_DC = 7'd100;

    // Conversion coefficients handed to the voltage converter
    typedef struct packed {
        logic        [15:0] scale;
        logic signed [15:0] offset;
        logic        [15:0] gain;
    } t_conv_cfg;

    // Converter response
    typedef struct packed {
        logic                     done;
        logic signed [VOLT_W-1:0] volts;
    } t_conv_rsp;

endpackage

`default_nettype wire

### rtl/ev_control_pilot_state_detector_core.sv
// Top level of the control-pilot state detector: averaging, conversion, debounce.
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+---------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | sample, relay_on; tuser operation
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | status, conv, volts, state, upd
//  cfg       | in        | i_cfg_valid / o_cfg_ready     | register index, 16-bit data
//
// One sample at a time. A sample that does not complete an average goes from the
// sample step through post-processing to the output. Completing an average adds the
// serial divider. A conversion adds two shift-add multiplies per phase, then a
// classification step. The result sits in an output register; a stalled
// output holds the next result back. Reset is synchronous and active low, no clearing pass.
`default_nettype none

module ev_control_pilot_state_detector_core
    import evcp_pkg::*;
#(
    parameter int AVG_LEN      = 16,
    parameter int DEBOUNCE_LEN = 4,
    parameter int SAMPLE_BITS  = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [11:0] sample, [12] relay_on, [15:13] zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  wire logic                   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [1:0] sample_status, [2] conversion_done, [18:3] high_voltage_q8,
    // [34:19] low_voltage_q8, [38:35] pilot_state, [39] state_updated
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SW     = (SAMPLE_BITS < SAMPLE_FIELD_W) ? SAMPLE_BITS : SAMPLE_FIELD_W;
    localparam int LEN_W  = $clog2(AVG_LEN);
    localparam int SUM_W  = SW + LEN_W;
    localparam int CNT_W  = LEN_W;
    localparam int REM_W  = LEN_W;
    localparam int DCNT_W = $clog2(SUM_W);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_POST   = 3'd2;
    localparam logic [2:0] S_CONV_H = 3'd3;
    localparam logic [2:0] S_CONV_L = 3'd4;
    localparam logic [2:0] S_CLASS  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    // Configuration registers
    logic [DUTY_W-1:0]  r_duty;
    logic [15:0]        r_scale;
    logic signed [15:0] r_offset;
    logic [15:0]        r_gain;
    logic signed [15:0] r_thr12;
    logic signed [15:0] r_thr9;
    logic signed [15:0] r_thr6;

    logic [2:0]               r_state, n_state;
    logic                     r_op, n_op;
    logic                     r_relay, n_relay;
    logic [STATUS_W-1:0]      r_status, n_status;
    logic                     r_conv, n_conv;
    logic                     r_upd, n_upd;
    logic [SUM_W-1:0]         r_hi_sum, n_hi_sum, r_lo_sum, n_lo_sum;
    logic [CNT_W-1:0]         r_hi_cnt, n_hi_cnt, r_lo_cnt, n_lo_cnt;
    logic [SW-1:0]            r_hi_avg, n_hi_avg, r_lo_avg, n_lo_avg;
    logic                     r_hi_done, n_hi_done, r_lo_done, n_lo_done;
    logic signed [VOLT_W-1:0] r_hi_volts, n_hi_volts, r_lo_volts, n_lo_volts;
    logic [CODE_W-1:0]        r_hist [DEBOUNCE_LEN];
    logic [CODE_W-1:0]        n_hist [DEBOUNCE_LEN];
    logic [CODE_W-1:0]        r_pstate, n_pstate;
    logic [REM_W-1:0]         r_rem, n_rem;
    logic [SUM_W-1:0]         r_quo, n_quo;
    logic [DCNT_W-1:0]        r_div_cnt, n_div_cnt;
    logic                     r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0]   r_out_data, n_out_data;

    logic                     in_xact;
    logic [SW-1:0]            smp;
    logic [SUM_W-1:0]         sel_sum;
    logic [CNT_W-1:0]         sel_cnt;
    logic                     sel_done;
    logic [SUM_W-1:0]         sum_add;
    logic [REM_W:0]           div_trial;
    logic                     div_bit;
    logic [CODE_W-1:0]        class_code;
    logic                     all_eq;
    logic                     is_pwm;
    logic                     conv_start;
    logic [SW-1:0]            conv_avg;
    t_conv_cfg                conv_cfg;
    t_conv_rsp                conv_rsp;

    assign in_xact       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty   <= DUTY_DC;
            r_scale  <= 16'd53;
            r_offset <= 16'sd422;
            r_gain   <= 16'd0;
            r_thr12  <= 16'sd2816;
            r_thr9   <= 16'sd2048;
            r_thr6   <= 16'sd1280;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_DUTY:   r_duty   <= i_cfg_data[DUTY_W-1:0];
                REG_SCALE:  r_scale  <= i_cfg_data;
                REG_OFFSET: r_offset <= i_cfg_data;
                REG_GAIN:   r_gain   <= i_cfg_data;
                REG_THR12:  r_thr12  <= i_cfg_data;
                REG_THR9:   r_thr9   <= i_cfg_data;
                REG_THR6:   r_thr6   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Select the phase accumulator named by the incoming transaction
    assign smp      = s_axis_tdata[SW-1:0];
    assign sel_sum  = s_axis_tuser ? r_lo_sum : r_hi_sum;
    assign sel_cnt  = s_axis_tuser ? r_lo_cnt : r_hi_cnt;
    assign sel_done = s_axis_tuser ? r_lo_done : r_hi_done;
    assign sum_add  = sel_sum + SUM_W'(smp);

    // One restoring-division step by AVG_LEN
    assign div_trial = {r_rem, r_quo[SUM_W-1]};
    assign div_bit   = (div_trial >= (REM_W+1)'(AVG_LEN));

    // Class of the high-phase voltage
    assign is_pwm = (r_duty != DUTY_DC);
    always_comb begin
        priority if (r_duty == '0) begin
            class_code = PS_DEFAULT;
        end else if (r_hi_volts >= r_thr12) begin
            class_code = is_pwm ? PS_PWM12 : PS_DC12;
        end else if (r_hi_volts >= r_thr9) begin
            class_code = is_pwm ? PS_PWM9 : PS_DC9;
        end else if (r_hi_volts >= r_thr6) begin
            class_code = is_pwm ? PS_PWM6 : PS_DC6;
        end else begin
            class_code = is_pwm ? PS_ERR_PWM : PS_ERR_DC;
        end
    end

    // Hand averages to the serial converter
    assign conv_start = ((r_state == S_POST) && r_relay && r_hi_done && r_lo_done)
                     || ((r_state == S_CONV_H) && conv_rsp.done);
    assign conv_avg   = (r_state == S_POST) ? r_hi_avg : r_lo_avg;
    assign conv_cfg.scale  = r_scale;
    assign conv_cfg.offset = r_offset;
    assign conv_cfg.gain   = r_gain;

    evcp_volt_conv #(
        .AVG_W (SW)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (conv_start),
        .i_avg   (conv_avg),
        .i_cfg   (conv_cfg),
        .o_rsp   (conv_rsp)
    );

    // Main sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_relay     = r_relay;
        n_status    = r_status;
        n_conv      = r_conv;
        n_upd       = r_upd;
        n_hi_sum    = r_hi_sum;
        n_lo_sum    = r_lo_sum;
        n_hi_cnt    = r_hi_cnt;
        n_lo_cnt    = r_lo_cnt;
        n_hi_avg    = r_hi_avg;
        n_lo_avg    = r_lo_avg;
        n_hi_done   = r_hi_done;
        n_lo_done   = r_lo_done;
        n_hi_volts  = r_hi_volts;
        n_lo_volts  = r_lo_volts;
        n_hist      = r_hist;
        n_pstate    = r_pstate;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div_cnt   = r_div_cnt;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        all_eq      = 1'b1;

        unique case (r_state)
            // Take a sample and advance its phase accumulator, unless that phase already holds an average
            S_IDLE: begin
                if (in_xact) begin
                    n_op    = s_axis_tuser;
                    n_relay = s_axis_tdata[SAMPLE_FIELD_W];
                    n_conv  = 1'b0;
                    n_upd   = 1'b0;
                    priority if (sel_done) begin
                        n_status = STS_IGNORED;
                        n_state  = S_POST;
                    end else if (sel_cnt == CNT_W'(AVG_LEN - 1)) begin
                        n_status  = STS_AVG_DONE;
                        n_quo     = sum_add;
                        n_rem     = '0;
                        n_div_cnt = DCNT_W'(SUM_W - 1);
                        n_state   = S_DIV;
                        if (s_axis_tuser) begin
                            n_lo_sum = '0;
                            n_lo_cnt = '0;
                        end else begin
                            n_hi_sum = '0;
                            n_hi_cnt = '0;
                        end
                    end else begin
                        n_status = STS_ACCUM;
                        n_state  = S_POST;
                        if (s_axis_tuser) begin
                            n_lo_sum = sum_add;
                            n_lo_cnt = r_lo_cnt + 1'b1;
                        end else begin
                            n_hi_sum = sum_add;
                            n_hi_cnt = r_hi_cnt + 1'b1;
                        end
                    end
                end
            end
            // Divide the finished sum by AVG_LEN, one quotient bit a cycle
            S_DIV: begin
                n_rem     = div_bit ? REM_W'(div_trial - (REM_W+1)'(AVG_LEN))
                                    : div_trial[REM_W-1:0];
                n_quo     = {r_quo[SUM_W-2:0], div_bit};
                n_div_cnt = r_div_cnt - 1'b1;
                if (r_div_cnt == '0) begin
                    if (r_op) begin
                        n_lo_avg  = n_quo[SW-1:0];
                        n_lo_done = 1'b1;
                    end else begin
                        n_hi_avg  = n_quo[SW-1:0];
                        n_hi_done = 1'b1;
                    end
                    n_state = S_POST;
                end
            end
            // Drop detection state on relay off, else start conversion when ready
            S_POST: begin
                if (!r_relay) begin
                    for (int i = 0; i < DEBOUNCE_LEN; i++) begin
                        n_hist[i] = PS_DEFAULT;
                    end
                    n_pstate   = PS_DEFAULT;
                    n_hi_volts = '0;
                    n_lo_volts = '0;
                    n_state    = S_OUT;
                end else if (r_hi_done && r_lo_done) begin
                    n_state = S_CONV_H;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_CONV_H: begin
                if (conv_rsp.done) begin
                    n_hi_volts = conv_rsp.volts;
                    n_state    = S_CONV_L;
                end
            end
            S_CONV_L: begin
                if (conv_rsp.done) begin
                    n_lo_volts = conv_rsp.volts;
                    n_hi_done  = 1'b0;
                    n_lo_done  = 1'b0;
                    n_conv     = 1'b1;
                    n_state    = S_CLASS;
                end
            end
            // Shift the class into the history and reload the state on agreement
            S_CLASS: begin
                n_hist[0] = class_code;
                for (int i = 1; i < DEBOUNCE_LEN; i++) begin
                    n_hist[i] = r_hist[i-1];
                end
                for (int i = 1; i < DEBOUNCE_LEN; i++) begin
                    if (n_hist[i] != class_code) begin
                        all_eq = 1'b0;
                    end
                end
                n_upd = all_eq;
                if (all_eq) begin
                    n_pstate = class_code;
                end
                n_state = S_OUT;
            end
            // Load the result once the output register is free
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_upd, r_pstate, r_lo_volts, r_hi_volts, r_conv, r_status};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_hi_sum    <= '0;
            r_lo_sum    <= '0;
            r_hi_cnt    <= '0;
            r_lo_cnt    <= '0;
            r_hi_avg    <= '0;
            r_lo_avg    <= '0;
            r_hi_done   <= 1'b0;
            r_lo_done   <= 1'b0;
            r_hi_volts  <= '0;
            r_lo_volts  <= '0;
            r_pstate    <= PS_DEFAULT;
            for (int i = 0; i < DEBOUNCE_LEN; i++) begin
                r_hist[i] <= PS_DEFAULT;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_hi_sum    <= n_hi_sum;
            r_lo_sum    <= n_lo_sum;
            r_hi_cnt    <= n_hi_cnt;
            r_lo_cnt    <= n_lo_cnt;
            r_hi_avg    <= n_hi_avg;
            r_lo_avg    <= n_lo_avg;
            r_hi_done   <= n_hi_done;
            r_lo_done   <= n_lo_done;
            r_hi_volts  <= n_hi_volts;
            r_lo_volts  <= n_lo_volts;
            r_pstate    <= n_pstate;
            r_hist      <= n_hist;
        end
        r_op       <= n_op;
        r_relay    <= n_relay;
        r_status   <= n_status;
        r_conv     <= n_conv;
        r_upd      <= n_upd;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_div_cnt  <= n_div_cnt;
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire

### rtl/evcp_volt_conv.sv
// Bit-serial conversion of one phase average into Q8 pilot volts.
`default_nettype none

module evcp_volt_conv
    import evcp_pkg::*;
#(
    parameter int AVG_W = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [AVG_W-1:0] i_avg,
    input  wire t_conv_cfg        i_cfg,
    output t_conv_rsp             o_rsp
);

    localparam int GAIN_W = 16;
    localparam int PROD_W = AVG_W + 16;
    localparam int DIFF_W = PROD_W + 2;
    localparam int ACC_W  = DIFF_W + GAIN_W;
    localparam int CNT_W  = $clog2((AVG_W > GAIN_W) ? AVG_W : GAIN_W);

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_MUL1 = 3'd1;
    localparam logic [2:0] C_DIFF = 3'd2;
    localparam logic [2:0] C_MUL2 = 3'd3;
    localparam logic [2:0] C_SAT  = 3'd4;

    localparam logic signed [DIFF_W-1:0] V_MAX = {{(DIFF_W-15){1'b0}}, 15'h7FFF};
    localparam logic signed [DIFF_W-1:0] V_MIN = {{(DIFF_W-15){1'b1}}, 15'h0000};

    logic [2:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [PROD_W-1:0]       r_mcand1, n_mcand1;
    logic [AVG_W-1:0]        r_mplier1, n_mplier1;
    logic [PROD_W-1:0]       r_prod, n_prod;
    logic [ACC_W-1:0]        r_mcand2, n_mcand2;
    logic [GAIN_W-1:0]       r_gain, n_gain;
    logic [ACC_W-1:0]        r_acc, n_acc;
    logic signed [VOLT_W-1:0] r_volts, n_volts;
    logic                    r_done, n_done;

    logic [DIFF_W-1:0]        off_ext;
    logic [DIFF_W-1:0]        diff;
    logic signed [DIFF_W-1:0] quo;

    // Offset in Q16 minus the scaled average
    assign off_ext = {{(DIFF_W-24){i_cfg.offset[15]}}, i_cfg.offset, 8'h00};
    assign diff    = off_ext - {2'b00, r_prod};
    // Floor division by 65536: drop the low fraction bits
    assign quo     = $signed(r_acc[ACC_W-1:GAIN_W]);

    // Sequence the two shift-add multiplications
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_mcand1  = r_mcand1;
        n_mplier1 = r_mplier1;
        n_prod    = r_prod;
        n_mcand2  = r_mcand2;
        n_gain    = r_gain;
        n_acc     = r_acc;
        n_volts   = r_volts;
        n_done    = 1'b0;
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    n_mcand1  = PROD_W'(i_cfg.scale);
                    n_mplier1 = i_avg;
                    n_prod    = '0;
                    n_cnt     = CNT_W'(AVG_W - 1);
                    n_state   = C_MUL1;
                end
            end
            C_MUL1: begin
                if (r_mplier1[0]) begin
                    n_prod = r_prod + r_mcand1;
                end
                n_mcand1  = r_mcand1 << 1;
                n_mplier1 = r_mplier1 >> 1;
                n_cnt     = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = C_DIFF;
                end
            end
            C_DIFF: begin
                n_mcand2 = {{GAIN_W{diff[DIFF_W-1]}}, diff};
                n_gain   = i_cfg.gain;
                n_acc    = '0;
                n_cnt    = CNT_W'(GAIN_W - 1);
                n_state  = C_MUL2;
            end
            C_MUL2: begin
                if (r_gain[0]) begin
                    n_acc = r_acc + r_mcand2;
                end
                n_mcand2 = r_mcand2 << 1;
                n_gain   = r_gain >> 1;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = C_SAT;
                end
            end
            C_SAT: begin
                priority if (quo > V_MAX) begin
                    n_volts = 16'sh7FFF;
                end else if (quo < V_MIN) begin
                    n_volts = -16'sh8000;
                end else begin
                    n_volts = quo[VOLT_W-1:0];
                end
                n_done  = 1'b1;
                n_state = C_IDLE;
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cnt     <= n_cnt;
        r_mcand1  <= n_mcand1;
        r_mplier1 <= n_mplier1;
        r_prod    <= n_prod;
        r_mcand2  <= n_mcand2;
        r_gain    <= n_gain;
        r_acc     <= n_acc;
        r_volts   <= n_volts;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.volts = r_volts;

endmodule

`default_nettype wire

### rtl/evcp_checker.sv
// Port-level checks of the control-pilot state detector, bound to the top level.
`default_nettype none

module evcp_checker
    import evcp_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic                out_xact;
    logic [STATUS_W-1:0] out_status;
    logic [CODE_W-1:0]   out_state;

    assign out_xact   = m_axis_tvalid && m_axis_tready;
    assign out_status = m_axis_tdata[1:0];
    assign out_state  = m_axis_tdata[38:35];

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // One sample in flight: input closes right after a transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second sample taken while one is in work");

    // A state reload only follows a conversion
    a_upd_needs_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xact && m_axis_tdata[39] |-> m_axis_tdata[2])
        else $error("state reload without conversion");

    // Status and state codes stay within their defined sets
    a_codes_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xact |-> (out_status <= STS_IGNORED) && (out_state <= PS_ERR_DC))
        else $error("undefined status or pilot state code");

endmodule

bind ev_control_pilot_state_detector_core evcp_checker u_evcp_checker (.*);

`default_nettype wire
